// ----- hdl/pom_pkg.sv -----
// Shared constants for the motion-sensor occupancy monitor: field widths,
// operation and result codes, and register reset values. No dependencies.
`default_nettype none

package pom_pkg;

    // Field widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned STAMP_W    = 16;
    localparam int unsigned SECONDS_W  = 32;
    localparam int unsigned ACC_W      = 16;
    localparam int unsigned RATIO_W    = 17;
    localparam int unsigned RELEASE_W  = 8;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 24;

    // Operation codes on the input tuser
    localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Result kinds on the output tuser
    localparam logic KIND_RATIO   = 1'b0;
    localparam logic KIND_MONITOR = 1'b1;

    // Full-scale ratio (Q1.16 one) and release time after reset
    localparam logic [RATIO_W-1:0]   FULL_SCALE    = 17'h10000;
    localparam logic [RELEASE_W-1:0] RELEASE_RESET = 8'd10;

    // Quotient bits produced by the serial divider
    localparam int unsigned DIV_STEPS = RATIO_W;

endpackage : pom_pkg

`default_nettype wire

// ----- hdl/pir_occupancy_monitor.sv -----
// Occupancy monitor for a motion-sensor output: high/low time accumulation,
// serial ratio divider and occupancy hold timer. Depends on pom_pkg.
//
// Usage:
//   Input transfers carry one event on s_axis: tuser selects edge event,
//   report request or monitor tick; tdata carries pin level, the 16-bit
//   fine timestamp and the 32-bit seconds count.
//   Edge events update the accumulators and give no result.
//   A report runs a restoring divider that produces one quotient bit per
//   cycle; the divider is set up at the transfer, runs its 17 steps and
//   then loads the ratio into the output register once that is free.
//   A report with both accumulators at zero skips the divider and its
//   result goes straight to the output register stage.
//   A monitor tick stages its result, which then waits for the output register.
//   s_axis_tready is low while a report divides and while a staged result
//   waits to move to the output register; so edges are taken every cycle
//   while idle, but no transfer is taken until a report or tick is handed on.
//   The m_axis output register holds a result until the receiver takes it;
//   a stalled receiver holds the block after one more result is finished.
//   Reset (synchronous, i_rst_n low) clears accumulators, timestamp, hold
//   state and output valid, and sets the release time to 10 seconds.
//   A configuration write sets the release time and clears the seen flag;
//   write it only while the block is idle.
`default_nettype none

module pir_occupancy_monitor
    import pom_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [RELEASE_W-1:0]  i_cfg_wdata,    // release_seconds
    // Event stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin_level, fine_time[16], whole_seconds[32]
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // operation
    // Result stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // occupancy_ratio[17], state_changed, occupied
    output logic                       m_axis_tuser    // result_kind
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    // Control and state registers
    t_state                 r_state;
    logic [RELEASE_W-1:0]   r_release;
    logic [ACC_W-1:0]       r_high;
    logic [ACC_W-1:0]       r_low;
    logic [STAMP_W-1:0]     r_last_stamp;
    logic                   r_rise_seen;
    logic                   r_hold_active;
    logic [SECONDS_W-1:0]   r_hold_start;

    // Divider registers
    logic [RATIO_W-1:0]     r_rem;
    logic [RATIO_W-1:0]     r_divisor;
    logic [RATIO_W-1:0]     r_quo;
    logic [CNT_W-1:0]       r_cnt;

    // Staged result and output register
    logic                   r_res_kind;
    logic [RATIO_W-1:0]     r_res_ratio;
    logic                   r_res_changed;
    logic                   r_res_occupied;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_kind;

    // Input field unpacking
    logic                   in_level;
    logic [STAMP_W-1:0]     in_stamp;
    logic [SECONDS_W-1:0]   in_now;
    logic                   in_fire;

    assign in_level = s_axis_tdata[0];
    assign in_stamp = s_axis_tdata[STAMP_W:1];
    assign in_now   = s_axis_tdata[STAMP_W+SECONDS_W:STAMP_W+1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Edge event: wrapped elapsed time, saturating accumulate
    logic [STAMP_W-1:0]     n_elapsed;
    logic [ACC_W:0]         n_acc_sum;
    logic [ACC_W-1:0]       n_acc_sat;

    always_comb begin
        n_elapsed = in_stamp - r_last_stamp;
        n_acc_sum = {1'b0, (in_level ? r_low : r_high)} + {1'b0, n_elapsed};
        n_acc_sat = n_acc_sum[ACC_W] ? {ACC_W{1'b1}} : n_acc_sum[ACC_W-1:0];
    end

    // Monitor tick: renew on seen flag, then check release time
    logic                   n_mid_active;
    logic [SECONDS_W-1:0]   n_mid_start;
    logic [SECONDS_W-1:0]   n_age;
    logic                   n_expire;
    logic                   n_tick_changed;
    logic                   n_tick_active;
    logic [SECONDS_W-1:0]   n_tick_start;

    always_comb begin
        n_mid_active   = r_rise_seen || r_hold_active;
        n_mid_start    = r_rise_seen ? in_now : r_hold_start;
        n_age          = in_now - n_mid_start;
        n_expire       = n_mid_active && (n_age > {{(SECONDS_W-RELEASE_W){1'b0}}, r_release});
        n_tick_changed = (r_rise_seen && !r_hold_active) || n_expire;
        n_tick_active  = n_mid_active && !n_expire;
        n_tick_start   = n_expire ? '0 : n_mid_start;
    end

    // Report setup: divisor is the sum of both accumulators
    logic [RATIO_W-1:0]     n_total;

    assign n_total = {1'b0, r_high} + {1'b0, r_low};

    // Compare/subtract unit for the divider: one quotient bit per step
    logic [RATIO_W:0]       n_trial;
    logic                   n_ge;
    logic [RATIO_W:0]       n_diff;

    always_comb begin
        n_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        n_ge    = (n_trial >= {1'b0, r_divisor});
        n_diff  = n_trial - {1'b0, r_divisor};
    end

    // Output register may take the staged result this cycle
    logic                   out_free;

    assign out_free = !r_out_valid || m_axis_tready;

    // State, datapath and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_release     <= RELEASE_RESET;
            r_high        <= '0;
            r_low         <= '0;
            r_last_stamp  <= '0;
            r_rise_seen   <= 1'b0;
            r_hold_active <= 1'b0;
            r_hold_start  <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // Drop the output once the receiver takes it
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_release   <= i_cfg_wdata;
                r_rise_seen <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (s_axis_tuser)
                            OP_EDGE: begin
                                if (in_level) begin
                                    r_low       <= n_acc_sat;
                                    r_rise_seen <= 1'b1;
                                end else begin
                                    r_high <= n_acc_sat;
                                end
                                r_last_stamp <= in_stamp;
                            end
                            OP_REPORT: begin
                                r_res_kind     <= KIND_RATIO;
                                r_res_ratio    <= '0;
                                r_res_changed  <= 1'b0;
                                r_res_occupied <= 1'b0;
                                r_rem          <= {1'b0, r_high};
                                r_divisor      <= n_total;
                                r_quo          <= '0;
                                r_cnt          <= '0;
                                r_high         <= '0;
                                r_low          <= '0;
                                r_last_stamp   <= in_stamp;
                                r_state        <= (n_total == '0) ? S_DONE : S_DIV;
                            end
                            OP_TICK: begin
                                r_res_kind     <= KIND_MONITOR;
                                r_res_ratio    <= '0;
                                r_res_changed  <= n_tick_changed;
                                r_res_occupied <= n_tick_active;
                                r_hold_active  <= n_tick_active;
                                r_hold_start   <= n_tick_start;
                                r_rise_seen    <= 1'b0;
                                r_state        <= S_DONE;
                            end
                            default: begin
                                // Unused code: take the transfer and ignore it
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // Advance the divider by one quotient bit
                    r_rem <= n_ge ? n_diff[RATIO_W-1:0] : n_trial[RATIO_W-1:0];
                    r_quo <= {r_quo[RATIO_W-2:0], n_ge};
                    if (r_cnt == LAST_STEP) begin
                        r_res_ratio <= {r_quo[RATIO_W-2:0], n_ge};
                        r_state     <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    // Hand the staged result to the output register
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{(OUT_DATA_W-RATIO_W-2){1'b0}}, r_res_occupied,
                                        r_res_changed, r_res_ratio};
                        r_out_kind  <= r_res_kind;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // Ratio reports never exceed full scale and carry no monitor flags
    a_ratio_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_RATIO)) |->
            ((m_axis_tdata[RATIO_W-1:0] <= FULL_SCALE) &&
             (m_axis_tdata[RATIO_W+1:RATIO_W] == 2'b00)))
        else $error("ratio result out of range or with monitor flags");

    // Monitor results carry a zero ratio field
    a_monitor_ratio : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_MONITOR)) |->
            (m_axis_tdata[RATIO_W-1:0] == '0))
        else $error("monitor result with nonzero ratio");

    // Divider never runs with a zero divisor and stays within its step count
    a_div_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_divisor != '0) && (r_cnt <= LAST_STEP)))
        else $error("divider step count or divisor invalid");

    // A released hold always clears its start time
    a_release_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_hold_active) && !$past(i_cfg_we)) |-> (r_hold_start == '0))
        else $error("hold released without clearing start time");

endmodule : pir_occupancy_monitor

`default_nettype wire
